>>> rtl/core/ftle_pkg.sv
package ftle_pkg;

  localparam int GridSizeDefault = 12;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;
  localparam int InDataW  = 48;
  localparam int InUserW  = 2;
  localparam int OutDataW = 24;
  localparam int OutUserW = 1;

  localparam logic [1:0] CmdTick = 2'd0;
  localparam logic [1:0] CmdLane = 2'd1;
  localparam logic [1:0] CmdRead = 2'd2;

  localparam logic [1:0] DirDown  = 2'd0;
  localparam logic [1:0] DirUp    = 2'd1;
  localparam logic [1:0] DirRight = 2'd2;
  localparam logic [1:0] DirLeft  = 2'd3;

  localparam logic [CfgIdxW-1:0] RegDirection = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSpawnThr  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTrailLen  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegColorIntv = 3'd3;
  localparam logic [CfgIdxW-1:0] RegColorEn   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBaseRed   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBaseGreen = 3'd6;
  localparam logic [CfgIdxW-1:0] RegBaseBlue  = 3'd7;

  localparam logic [1:0] ChanRed   = 2'd0;
  localparam logic [1:0] ChanGreen = 2'd1;
  localparam logic [1:0] ChanBlue  = 2'd2;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [4:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/core/ftle_div.sv
module ftle_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftle_pkg::div_req_t  req_i,
  output ftle_pkg::div_rsp_t  rsp_o
);
  import ftle_pkg::*;

  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] dvd_q, dvd_d;
  logic [4:0] dvs_q, dvs_d;
  logic [4:0] rem_q, rem_d;
  logic [7:0] quo_q, quo_d;
  logic [5:0] trial;
  logic       fits;

  assign trial = {rem_q, dvd_q[7]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      // one quotient bit per cycle, restoring
      rem_d = fits ? 5'(trial - {1'b0, dvs_q}) : trial[4:0];
      quo_d = {quo_q[6:0], fits};
      dvd_d = {dvd_q[6:0], 1'b0};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  a_start_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && !done_q)
    else $error("divider did not start");
  a_remainder_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dvs_q)
    else $error("divider remainder out of range");
`endif

endmodule

>>> rtl/core/falling_trail_led_effect.sv
// Falling-trail LED effect over a GRID_SIZE x GRID_SIZE RGB frame store held in a one-read,
// one-write memory. After reset a clearing pass writes every pixel to black while
// s_axis_tready stays low. A frame tick moves the frame one pixel through the single memory
// read and write port, one pixel per cycle. A lane update on an active lane runs three
// divisions on one shared restoring divider plus start, multiply and fade steps; an idle or
// newly black lane skips them. A pixel read passes through S_RREQ and S_ROUT. One item is
// handled at a time; a result sits in the output register until taken while the next item
// is accepted.
module falling_trail_led_effect #(
  parameter int GRID_SIZE = ftle_pkg::GridSizeDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ftle_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ftle_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // draw_red, draw_green, draw_blue, lane, lane_draw, read_row, read_col, zero pad
  input  logic [ftle_pkg::InDataW-1:0]   s_axis_tdata,
  // command
  input  logic [ftle_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_red, out_green, out_blue
  output logic [ftle_pkg::OutDataW-1:0]  m_axis_tdata,
  // out_kind
  output logic [ftle_pkg::OutUserW-1:0]  m_axis_tuser
);
  import ftle_pkg::*;

  localparam int N  = GRID_SIZE * GRID_SIZE;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(GRID_SIZE);
  localparam logic [AW-1:0] LastAddr = AW'(N - 1);
  localparam logic [CW-1:0] LastIdx  = CW'(GRID_SIZE - 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCROLL = 4'd2;
  localparam logic [3:0] S_TAIL   = 4'd3;
  localparam logic [3:0] S_LSETUP = 4'd4;
  localparam logic [3:0] S_LSTART = 4'd5;
  localparam logic [3:0] S_LDIV   = 4'd6;
  localparam logic [3:0] S_LFADE  = 4'd7;
  localparam logic [3:0] S_LOUT   = 4'd8;
  localparam logic [3:0] S_RREQ   = 4'd9;
  localparam logic [3:0] S_ROUT   = 4'd10;

  logic [3:0] state_q, state_d;

  // configuration
  logic [1:0] dir_q;
  logic [6:0] spawn_thr_q;
  logic [4:0] trail_len_q;
  logic [6:0] color_intv_q;
  logic       color_en_q;
  logic [7:0] cur_r_q, cur_g_q, cur_b_q;
  logic [6:0] color_cnt_q;

  // captured item
  logic [3:0] lane_q;
  logic [6:0] lane_draw_q;
  logic [3:0] rd_row_q, rd_col_q;

  // scroll walk
  logic [AW-1:0] addr_q, addr_d;
  logic [CW-1:0] row_q, row_d, col_q, col_d;
  logic          desc_q;
  logic          pend_q;
  logic [AW-1:0] pdst_q;

  // lane state
  logic       lane_act_q [GRID_SIZE];
  logic [4:0] lane_pos_q [GRID_SIZE];
  logic       act_q;
  logic [4:0] pos_q;
  logic [1:0] chan_q;
  logic [12:0] prod_q;
  logic [7:0] px_r_q, px_g_q, px_b_q;

  // output register
  logic       out_valid_q;
  logic [7:0] out_r_q, out_g_q, out_b_q;
  logic       out_kind_q;
  logic       out_free;

  // memory
  logic [23:0]   mem [N];
  logic [23:0]   rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [23:0]   mem_wdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic          in_xfer;
  logic [1:0]    cmd;
  logic [CW-1:0] lidx;
  logic          lane_oob;
  logic          spawn;
  logic [4:0]    len_eff;
  logic [5:0]    pos_next;
  logic [AW-1:0] lane_a, edge_addr, rd_addr;
  logic          rd_oob;
  logic          skip;
  logic          walk_last;
  logic [AW-1:0] src_addr;
  logic [7:0]    chan_color;
  logic [7:0]    fade;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cmd           = s_axis_tuser;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign lidx     = CW'(lane_q);
  assign lane_oob = 32'(lane_q) >= GRID_SIZE;
  assign spawn    = lane_draw_q < spawn_thr_q;
  assign len_eff  = (trail_len_q == 5'd0) ? 5'd1 : trail_len_q;
  assign pos_next = {1'b0, pos_q} + 6'd1;

  assign lane_a = AW'(lane_q);
  always_comb begin
    case (dir_q)
      DirDown:  edge_addr = lane_a;
      DirUp:    edge_addr = AW'((GRID_SIZE - 1) * GRID_SIZE) + lane_a;
      DirRight: edge_addr = AW'(lane_a * GRID_SIZE);
      default:  edge_addr = AW'(lane_a * GRID_SIZE + GRID_SIZE - 1);
    endcase
  end

  assign rd_addr = AW'(32'(rd_row_q) * GRID_SIZE + 32'(rd_col_q));
  assign rd_oob  = (32'(rd_row_q) >= GRID_SIZE) || (32'(rd_col_q) >= GRID_SIZE);

  // scroll: skip the entry edge, source is one row or column behind
  always_comb begin
    case (dir_q)
      DirDown: begin
        skip     = (row_q == '0);
        src_addr = addr_q - AW'(GRID_SIZE);
      end
      DirUp: begin
        skip     = (row_q == LastIdx);
        src_addr = addr_q + AW'(GRID_SIZE);
      end
      DirRight: begin
        skip     = (col_q == '0);
        src_addr = addr_q - AW'(1);
      end
      default: begin
        skip     = (col_q == LastIdx);
        src_addr = addr_q + AW'(1);
      end
    endcase
  end

  assign walk_last = desc_q ? (addr_q == '0) : (addr_q == LastAddr);

  always_comb begin
    addr_d = addr_q;
    row_d  = row_q;
    col_d  = col_q;
    if (state_q == S_CLEAR) begin
      addr_d = addr_q + AW'(1);
    end else if (in_xfer) begin
      if (dir_q == DirDown || dir_q == DirRight) begin
        addr_d = LastAddr;
        row_d  = LastIdx;
        col_d  = LastIdx;
      end else begin
        addr_d = '0;
        row_d  = '0;
        col_d  = '0;
      end
    end else if (state_q == S_SCROLL) begin
      if (desc_q) begin
        addr_d = addr_q - AW'(1);
        if (col_q == '0) begin
          col_d = LastIdx;
          row_d = row_q - CW'(1);
        end else begin
          col_d = col_q - CW'(1);
        end
      end else begin
        addr_d = addr_q + AW'(1);
        if (col_q == LastIdx) begin
          col_d = '0;
          row_d = row_q + CW'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  always_comb begin
    case (chan_q)
      ChanRed:   chan_color = cur_r_q;
      ChanGreen: chan_color = cur_g_q;
      default:   chan_color = cur_b_q;
    endcase
  end

  assign fade = (prod_q >= {5'd0, chan_color}) ? 8'd0 : 8'(chan_color - prod_q[7:0]);

  assign div_req.start    = (state_q == S_LSTART);
  assign div_req.dividend = chan_color;
  assign div_req.divisor  = len_eff;

  ftle_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (addr_q == LastAddr) state_d = S_IDLE;
      S_IDLE: begin
        if (in_xfer) begin
          case (cmd)
            CmdTick: state_d = S_SCROLL;
            CmdLane: state_d = S_LSETUP;
            CmdRead: state_d = S_RREQ;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCROLL: if (walk_last) state_d = S_TAIL;
      S_TAIL:   state_d = S_IDLE;
      S_LSETUP: begin
        if (lane_oob) begin
          state_d = S_IDLE;
        end else if (spawn || lane_act_q[lidx]) begin
          state_d = S_LSTART;
        end else begin
          state_d = S_LOUT;
        end
      end
      S_LSTART: state_d = S_LDIV;
      S_LDIV:   if (div_rsp.done) state_d = S_LFADE;
      S_LFADE:  state_d = (chan_q == ChanBlue) ? S_LOUT : S_LSTART;
      S_LOUT:   if (out_free) state_d = S_IDLE;
      S_RREQ:   state_d = S_ROUT;
      S_ROUT:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = edge_addr;
    mem_wdata = {px_r_q, px_g_q, px_b_q};
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = addr_q;
      mem_wdata = '0;
    end else if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = pdst_q;
      mem_wdata = rdata_q;
    end else if (state_q == S_LOUT && out_free) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = (state_q == S_SCROLL) ? src_addr : rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
      desc_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      row_q   <= row_d;
      col_q   <= col_d;
      pend_q  <= (state_q == S_SCROLL) && !skip;
      if (in_xfer) begin
        desc_q <= (dir_q == DirDown) || (dir_q == DirRight);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pdst_q <= addr_q;
  end

  // configuration and color
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q        <= DirDown;
      spawn_thr_q  <= 7'd10;
      trail_len_q  <= 5'd6;
      color_intv_q <= 7'd50;
      color_en_q   <= 1'b1;
      cur_r_q      <= 8'd255;
      cur_g_q      <= 8'd0;
      cur_b_q      <= 8'd0;
      color_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegDirection: dir_q        <= cfg_data_i[1:0];
          RegSpawnThr:  spawn_thr_q  <= cfg_data_i[6:0];
          RegTrailLen:  trail_len_q  <= cfg_data_i[4:0];
          RegColorIntv: color_intv_q <= cfg_data_i[6:0];
          RegColorEn:   color_en_q   <= cfg_data_i[0];
          RegBaseRed:   cur_r_q      <= cfg_data_i;
          RegBaseGreen: cur_g_q      <= cfg_data_i;
          RegBaseBlue:  cur_b_q      <= cfg_data_i;
          default:      ;
        endcase
      end
      if (in_xfer && cmd == CmdTick && color_en_q) begin
        if (color_cnt_q > color_intv_q) begin
          cur_r_q     <= s_axis_tdata[7:0];
          cur_g_q     <= s_axis_tdata[15:8];
          cur_b_q     <= s_axis_tdata[23:16];
          color_cnt_q <= '0;
        end else begin
          color_cnt_q <= color_cnt_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      lane_q      <= s_axis_tdata[27:24];
      lane_draw_q <= s_axis_tdata[34:28];
      rd_row_q    <= s_axis_tdata[38:35];
      rd_col_q    <= s_axis_tdata[42:39];
    end
  end

  // lane sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GRID_SIZE; i++) begin
        lane_act_q[i] <= 1'b0;
        lane_pos_q[i] <= '0;
      end
      act_q  <= 1'b0;
      chan_q <= ChanRed;
    end else begin
      if (state_q == S_LSETUP) begin
        act_q  <= spawn || lane_act_q[lidx];
        chan_q <= ChanRed;
      end
      if (state_q == S_LFADE) begin
        chan_q <= chan_q + 2'd1;
      end
      if (state_q == S_LOUT && out_free && act_q) begin
        if (pos_next > {1'b0, len_eff}) begin
          lane_act_q[lidx] <= 1'b0;
          lane_pos_q[lidx] <= '0;
        end else begin
          lane_act_q[lidx] <= 1'b1;
          lane_pos_q[lidx] <= pos_next[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LSETUP) begin
      pos_q  <= spawn ? 5'd0 : lane_pos_q[lidx];
      px_r_q <= '0;
      px_g_q <= '0;
      px_b_q <= '0;
    end
    if (state_q == S_LDIV && div_rsp.done) begin
      prod_q <= pos_q * div_rsp.quot;
    end
    if (state_q == S_LFADE) begin
      case (chan_q)
        ChanRed:   px_r_q <= fade;
        ChanGreen: px_g_q <= fade;
        default:   px_b_q <= fade;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_LOUT || state_q == S_ROUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOUT && out_free) begin
      out_r_q    <= px_r_q;
      out_g_q    <= px_g_q;
      out_b_q    <= px_b_q;
      out_kind_q <= 1'b0;
    end else if (state_q == S_ROUT && out_free) begin
      out_r_q    <= rd_oob ? 8'd0 : rdata_q[23:16];
      out_g_q    <= rd_oob ? 8'd0 : rdata_q[15:8];
      out_b_q    <= rd_oob ? 8'd0 : rdata_q[7:0];
      out_kind_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_b_q, out_g_q, out_r_q};
  assign m_axis_tuser  = out_kind_q;

`ifndef SYNTHESIS
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCROLL && mem_we) |-> mem_raddr != mem_waddr)
    else $error("scroll reads a pixel being written");
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_we)
    else $error("memory written while idle");
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_LDIV)
    else $error("divider result outside the division step");
  a_pend_after_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q) == S_SCROLL)
    else $error("pending scroll write without a scroll read");
`endif

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ftle_pkg::*;

  localparam int Grid       = GridSizeDefault;
  localparam int DrainWait  = 200;
  localparam int IdleLimit  = 4000;
  localparam int HoldOff    = 300;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic       KindLane  = 1'b0;
  localparam logic       KindRead  = 1'b1;

  // input item, last listed field in the lowest bits
  typedef struct packed {
    logic [4:0] pad;
    logic [3:0] read_col;
    logic [3:0] read_row;
    logic [6:0] lane_draw;
    logic [3:0] lane;
    logic [7:0] draw_blue;
    logic [7:0] draw_green;
    logic [7:0] draw_red;
  } item_fields_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } out_fields_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       kind;
  } pixel_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // draw_red, draw_green, draw_blue, lane, lane_draw, read_row, read_col, zero pad
  logic [InDataW-1:0]  s_axis_tdata;
  // command
  logic [InUserW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // out_red, out_green, out_blue
  logic [OutDataW-1:0] m_axis_tdata;
  // out_kind
  logic [OutUserW-1:0] m_axis_tuser;

  falling_trail_led_effect dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow copy of the effect state
  logic [23:0] frame_copy [Grid*Grid] = '{default: '0};
  logic        lane_on [Grid] = '{default: 1'b0};
  logic [4:0]  lane_pos [Grid] = '{default: '0};
  logic [6:0]  color_cnt = '0;
  logic [7:0]  cur_red = 8'd255;
  logic [7:0]  cur_green = 8'd0;
  logic [7:0]  cur_blue = 8'd0;
  logic [1:0]  cfg_dir = DirDown;
  logic [6:0]  cfg_spawn = 7'd10;
  logic [4:0]  cfg_len = 5'd6;
  logic [6:0]  cfg_intv = 7'd50;
  logic        cfg_color_en = 1'b1;

  pixel_t expected_pixels [$];
  int     err_cnt = 0;
  int     idle_cycles = 0;
  int     hold_cycles = 0;
  bit     no_idle = 1'b0;

  function automatic logic [7:0] faded(input logic [7:0] colour, input int pos, input int len);
    int step;
    step = pos * (colour / len);
    return (step >= colour) ? 8'd0 : 8'(colour - step);
  endfunction

  function automatic void scroll_frame_copy();
    case (cfg_dir)
      DirDown:
        for (int r = Grid - 1; r >= 1; r--)
          for (int c = 0; c < Grid; c++) frame_copy[r*Grid+c] = frame_copy[(r-1)*Grid+c];
      DirUp:
        for (int r = 0; r + 1 < Grid; r++)
          for (int c = 0; c < Grid; c++) frame_copy[r*Grid+c] = frame_copy[(r+1)*Grid+c];
      DirRight:
        for (int r = 0; r < Grid; r++)
          for (int c = Grid - 1; c >= 1; c--) frame_copy[r*Grid+c] = frame_copy[r*Grid+c-1];
      default:
        for (int r = 0; r < Grid; r++)
          for (int c = 0; c + 1 < Grid; c++) frame_copy[r*Grid+c] = frame_copy[r*Grid+c+1];
    endcase
  endfunction

  task automatic predict_item(input logic [1:0] cmd, input item_fields_t f);
    int     len;
    int     row;
    int     col;
    int     nxt;
    pixel_t px;
    px = '0;
    case (cmd)
      CmdTick: begin
        if (cfg_color_en) begin
          if (color_cnt > cfg_intv) begin
            cur_red   = f.draw_red;
            cur_green = f.draw_green;
            cur_blue  = f.draw_blue;
            color_cnt = '0;
          end else begin
            color_cnt = color_cnt + 7'd1;
          end
        end
        scroll_frame_copy();
      end
      CmdLane: begin
        if (f.lane < Grid) begin
          len = (cfg_len == 5'd0) ? 1 : int'(cfg_len);
          if (f.lane_draw < cfg_spawn) begin
            lane_on[f.lane]  = 1'b1;
            lane_pos[f.lane] = '0;
          end
          if (lane_on[f.lane]) begin
            px.red   = faded(cur_red, lane_pos[f.lane], len);
            px.green = faded(cur_green, lane_pos[f.lane], len);
            px.blue  = faded(cur_blue, lane_pos[f.lane], len);
            nxt = int'(lane_pos[f.lane]) + 1;
            if (nxt > len) begin
              lane_on[f.lane]  = 1'b0;
              lane_pos[f.lane] = '0;
            end else begin
              lane_pos[f.lane] = 5'(nxt);
            end
          end
          case (cfg_dir)
            DirDown: begin
              row = 0;
              col = f.lane;
            end
            DirUp: begin
              row = Grid - 1;
              col = f.lane;
            end
            DirRight: begin
              row = f.lane;
              col = 0;
            end
            default: begin
              row = f.lane;
              col = Grid - 1;
            end
          endcase
          frame_copy[row*Grid+col] = {px.red, px.green, px.blue};
          px.kind = KindLane;
          expected_pixels.push_back(px);
        end
      end
      CmdRead: begin
        if (f.read_row < Grid && f.read_col < Grid)
          {px.red, px.green, px.blue} = frame_copy[f.read_row*Grid+f.read_col];
        px.kind = KindRead;
        expected_pixels.push_back(px);
      end
      default: ;
    endcase
  endtask

  function automatic item_fields_t random_fields();
    logic [63:0]  bits;
    item_fields_t f;
    bits = {$urandom, $urandom};
    f = bits[InDataW-1:0];
    f.pad = '0;
    return f;
  endfunction

  function automatic logic [6:0] pick_draw();
    if ($urandom_range(0, 7) == 0) return 7'($urandom_range(100, 127));
    return 7'($urandom_range(0, 99));
  endfunction

  function automatic logic [3:0] pick_coord();
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(Grid, 15));
    return 4'($urandom_range(0, Grid - 1));
  endfunction

  function automatic item_fields_t lane_fields(input logic [3:0] lane, input logic [6:0] draw);
    item_fields_t f;
    f = random_fields();
    f.lane = lane;
    f.lane_draw = draw;
    return f;
  endfunction

  function automatic item_fields_t read_fields(input logic [3:0] row, input logic [3:0] col);
    item_fields_t f;
    f = random_fields();
    f.read_row = row;
    f.read_col = col;
    return f;
  endfunction

  function automatic item_fields_t tick_fields(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    item_fields_t f;
    f = random_fields();
    f.draw_red = r;
    f.draw_green = g;
    f.draw_blue = b;
    return f;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input item_fields_t f);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= f;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(cmd, f);
  endtask

  // sender stops until every result is back, then lets a frame tick finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegDirection: cfg_dir = value[1:0];
      RegSpawnThr:  cfg_spawn = value[6:0];
      RegTrailLen:  cfg_len = value[4:0];
      RegColorIntv: cfg_intv = value[6:0];
      RegColorEn:   cfg_color_en = value[0];
      RegBaseRed:   cur_red = value;
      RegBaseGreen: cur_green = value;
      RegBaseBlue:  cur_blue = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [1:0] dir, input logic [6:0] spawn,
                               input logic [4:0] len, input logic [6:0] intv, input logic en,
                               input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    settle();
    write_reg(RegDirection, 8'(dir));
    write_reg(RegSpawnThr, 8'(spawn));
    write_reg(RegTrailLen, 8'(len));
    write_reg(RegColorIntv, 8'(intv));
    write_reg(RegColorEn, 8'(en));
    write_reg(RegBaseRed, r);
    write_reg(RegBaseGreen, g);
    write_reg(RegBaseBlue, b);
  endtask

  // mostly whole frames: tick, every lane once, a few reads; the rest noise
  task automatic run_traffic(input int n_items);
    int           n;
    int           n_reads;
    logic [1:0]   cmd;
    item_fields_t f;
    n = 0;
    while (n < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(CmdTick, random_fields());
        for (int l = 0; l < Grid; l++) send_item(CmdLane, lane_fields(4'(l), pick_draw()));
        n_reads = $urandom_range(0, 3);
        for (int i = 0; i < n_reads; i++)
          send_item(CmdRead, read_fields(pick_coord(), pick_coord()));
        n += 1 + Grid + n_reads;
      end else begin
        f = random_fields();
        cmd = 2'($urandom_range(0, 3));
        if (cmd == CmdLane) f.lane_draw = pick_draw();
        send_item(cmd, f);
        if (!(cmd == CmdUnused || (cmd == CmdLane && f.lane >= Grid))) n++;
      end
    end
  endtask

  task automatic test_reset_state();
    item_fields_t f;
    send_item(CmdRead, read_fields(4'd0, 4'd0));
    send_item(CmdRead, read_fields(4'(Grid - 1), 4'(Grid - 1)));
    send_item(CmdRead, read_fields(4'd15, 4'd0));
    send_item(CmdRead, read_fields(4'd4, 4'd15));
    send_item(CmdLane, lane_fields(4'(Grid - 1), 7'd127));
    // out of range lanes and the unused command leave no trace
    send_item(CmdLane, lane_fields(4'(Grid), 7'd0));
    send_item(CmdLane, lane_fields(4'd15, 7'd0));
    f = '1;
    f.pad = '0;
    send_item(CmdUnused, f);
  endtask

  task automatic test_trail_basics();
    send_item(CmdLane, lane_fields(4'd0, 7'd0));
    send_item(CmdLane, lane_fields(4'd0, 7'd99));
    send_item(CmdTick, tick_fields(8'd0, 8'd255, 8'd0));
    send_item(CmdRead, read_fields(4'd1, 4'd0));
    send_item(CmdRead, read_fields(4'd0, 4'd0));
    // zero trail length behaves as length one
    settle();
    write_reg(RegTrailLen, 8'd0);
    write_reg(RegBaseGreen, 8'd255);
    write_reg(RegBaseBlue, 8'd128);
    send_item(CmdLane, lane_fields(4'd3, 7'd0));
    send_item(CmdLane, lane_fields(4'd3, 7'd99));
    send_item(CmdLane, lane_fields(4'd3, 7'd99));
    settle();
    write_reg(RegColorIntv, 8'd0);
    send_item(CmdTick, tick_fields(8'd255, 8'd0, 8'd255));
    send_item(CmdTick, tick_fields(8'd0, 8'd0, 8'd0));
    send_item(CmdLane, lane_fields(4'd4, 7'd0));
    send_item(CmdRead, read_fields(4'd2, 4'd3));
  endtask

  task automatic test_directions();
    logic [1:0] dirs [4];
    dirs = '{DirDown, DirUp, DirRight, DirLeft};
    settle();
    write_reg(RegTrailLen, 8'd8);
    write_reg(RegSpawnThr, 8'd40);
    write_reg(RegColorIntv, 8'd3);
    foreach (dirs[i]) begin
      settle();
      write_reg(RegDirection, 8'(dirs[i]));
      run_traffic(150);
    end
  endtask

  task automatic test_setting_sweep();
    apply_setting(DirLeft, 7'd0, 5'd31, 7'd127, 1'b0, 8'd0, 8'd0, 8'd0);
    run_traffic(150);
    apply_setting(DirUp, 7'd127, 5'd1, 7'd0, 1'b1, 8'd255, 8'd255, 8'd255);
    run_traffic(150);
    apply_setting(DirRight, 7'd100, 5'd30, 7'd100, 1'b1, 8'd200, 8'd17, 8'd99);
    run_traffic(150);
    repeat (3) begin
      apply_setting(2'($urandom), 7'($urandom_range(0, 127)), 5'($urandom),
                    7'($urandom_range(0, 12)), 1'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
      run_traffic(150);
    end
  endtask

  task automatic test_no_idle();
    settle();
    write_reg(RegSpawnThr, 8'd60);
    no_idle = 1'b1;
    run_traffic(100);
    no_idle = 1'b0;
  endtask

  // sink holds off while the source keeps offering, so the block backs up
  task automatic test_output_hold_off();
    settle();
    hold_cycles = HoldOff;
    no_idle = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 2 == 1) send_item(CmdLane, lane_fields(4'(i % Grid), pick_draw()));
      else send_item(CmdRead, read_fields(pick_coord(), pick_coord()));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= RegDirection;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CmdTick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();
    test_reset_state();
    test_trail_basics();
    test_directions();
    test_setting_sweep();
    test_no_idle();
    test_output_hold_off();
    settle();
    if (err_cnt == 0 && expected_pixels.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin : result_check
    pixel_t      want;
    out_fields_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_pixels.size() == 0) begin
        $error("unexpected transfer: tdata %h tuser %0d", m_axis_tdata, m_axis_tuser);
        err_cnt++;
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.red) begin
          $error("out_red: expected %0d, actual %0d", want.red, got.red);
          err_cnt++;
        end
        if (got.green !== want.green) begin
          $error("out_green: expected %0d, actual %0d", want.green, got.green);
          err_cnt++;
        end
        if (got.blue !== want.blue) begin
          $error("out_blue: expected %0d, actual %0d", want.blue, got.blue);
          err_cnt++;
        end
        if (m_axis_tuser[0] !== want.kind) begin
          $error("out_kind: expected %0d, actual %0d", want.kind, m_axis_tuser[0]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule
